/* design/lbh_pkg.sv */
// Shared types and constants for the log2 latency / batch histogram.
// No dependencies; imported by every module of the block but the cell memory.
`default_nettype none
package lbh_pkg;

  localparam int LBH_LAT_W  = 64;
  localparam int LBH_REQ_W  = 16;
  localparam int LBH_BYTE_W = 32;
  localparam int LBH_THR_W  = 32;
  localparam int LBH_CNT_W  = 32;
  localparam int LBH_TOT_W  = 48;
  localparam int LBH_ROW_W  = 3;
  localparam int LBH_COL_W  = 2;

  localparam logic [LBH_THR_W-1:0] LBH_THR_RESET = 32'd1024;

  localparam logic LBH_CMD_PLAIN  = 1'b0;
  localparam logic LBH_CMD_BATCH  = 1'b1;
  localparam logic LBH_KIND_STAT  = 1'b0;
  localparam logic LBH_KIND_CELL  = 1'b1;
  localparam logic LBH_STAT_OK    = 1'b0;
  localparam logic LBH_STAT_REJ   = 1'b1;

  // Control from the sequencer to the running totals
  typedef struct packed {
    logic add;
    logic clear;
  } lbh_tot_ctl_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_WRITE = 6'b000100,
    S_DRD   = 6'b001000,
    S_DCHK  = 6'b010000,
    S_FLUSH = 6'b100000
  } lbh_state_e;

endpackage
`default_nettype wire

/* design/lbh_cell_ram.sv */
// Single-port histogram cell memory with registered read data.
// Depends on nothing but its parameters.
`default_nettype none
module lbh_cell_ram #(
  parameter int DEPTH  = 32,
  parameter int AW     = 5,
  parameter int DW     = 32
) (
  input  wire logic          clk_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic          re_i,
  input  wire logic          we_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // read returns the old word when written in the same cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* design/lbh_bin_map.sv */
// Maps an input word to its histogram cell: row by leading one, column by batch size.
// Uses lbh_pkg for field widths and command codes.
`default_nettype none
module lbh_bin_map #(
  parameter int LATENCY_BINS = 8,
  parameter int BATCH_BINS   = 4,
  parameter int RW           = 3,
  parameter int CW           = 2,
  parameter int AW           = 5
) (
  input  wire logic                          cmd_i,
  input  wire logic [lbh_pkg::LBH_LAT_W-1:0] latency_i,
  input  wire logic [lbh_pkg::LBH_REQ_W-1:0] req_count_i,
  output logic      [AW-1:0]                 addr_o
);
  import lbh_pkg::*;

  logic [RW-1:0] row_sel;
  logic [CW-1:0] col_sel;

  // Highest set bit, clamped to the last row; zero and one both land in row 0
  always_comb begin
    row_sel = '0;
    for (int r = 1; r < LATENCY_BINS; r++) begin
      if ((latency_i >> r) != '0) begin
        row_sel = RW'(r);
      end
    end
  end

  always_comb begin
    if (cmd_i == LBH_CMD_PLAIN) begin
      col_sel = '0;
    end else if (req_count_i[LBH_REQ_W-2:0] > (LBH_REQ_W-1)'(BATCH_BINS - 1)) begin
      col_sel = CW'(BATCH_BINS - 1);
    end else begin
      col_sel = CW'(req_count_i[LBH_REQ_W-2:0]);
    end
  end

  assign addr_o = AW'(row_sel) * AW'(BATCH_BINS) + AW'(col_sel);

endmodule
`default_nettype wire

/* design/lbh_totals.sv */
// Saturating request and byte totals with the dump threshold compare.
// Uses lbh_pkg for widths and the control struct.
`default_nettype none
module lbh_totals (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire lbh_pkg::lbh_tot_ctl_t                ctl_i,
  input  wire logic        [lbh_pkg::LBH_REQ_W-1:0] req_count_i,
  input  wire logic signed [lbh_pkg::LBH_BYTE_W-1:0] req_bytes_i,
  input  wire logic        [lbh_pkg::LBH_THR_W-1:0] thr_i,
  output logic             [lbh_pkg::LBH_TOT_W-1:0] total_req_o,
  output logic signed      [lbh_pkg::LBH_TOT_W-1:0] total_bytes_o,
  output logic                                      hit_o
);
  import lbh_pkg::*;

  logic        [LBH_TOT_W-1:0] req_q, req_d;
  logic signed [LBH_TOT_W-1:0] byt_q, byt_d;
  logic        [LBH_TOT_W:0]   req_sum;
  logic signed [LBH_TOT_W:0]   byt_sum;

  // count is known positive when added
  assign req_sum = {1'b0, req_q} + (LBH_TOT_W+1)'(req_count_i[LBH_REQ_W-2:0]);
  assign byt_sum = (LBH_TOT_W+1)'(byt_q) + (LBH_TOT_W+1)'(req_bytes_i);

  always_comb begin
    req_d = req_q;
    byt_d = byt_q;
    if (ctl_i.clear) begin
      req_d = '0;
      byt_d = '0;
    end else if (ctl_i.add) begin
      req_d = req_sum[LBH_TOT_W] ? '1 : req_sum[LBH_TOT_W-1:0];
      // clamp on sign overflow
      if (byt_sum[LBH_TOT_W] != byt_sum[LBH_TOT_W-1]) begin
        byt_d = byt_sum[LBH_TOT_W] ? {1'b1, {(LBH_TOT_W-1){1'b0}}}
                                   : {1'b0, {(LBH_TOT_W-1){1'b1}}};
      end else begin
        byt_d = byt_sum[LBH_TOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0;
      byt_q <= '0;
    end else begin
      req_q <= req_d;
      byt_q <= byt_d;
    end
  end

  assign total_req_o   = req_q;
  assign total_bytes_o = byt_q;
  assign hit_o         = req_q >= LBH_TOT_W'(thr_i);

endmodule
`default_nettype wire

/* design/log2_latency_batch_histogram_unit.sv */
// An item is accepted in idle with a cell read; the write state writes back the cell plus
// one (unless rejected) and loads the status word into the output register once the slot
// is free. A dump reads and zeroes each cell, then checks it, and emits the last cell at
// the end, all through the single memory port; the block takes no input in either case.
// Reset: asynchronous, active low; then a clearing pass that zeroes every cell.
`default_nettype none
module log2_latency_batch_histogram_unit #(
  parameter int LATENCY_BINS = 8,
  parameter int BATCH_BINS   = 4
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic        [lbh_pkg::LBH_THR_W-1:0]  cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  cmd_i,
  input  wire logic        [lbh_pkg::LBH_LAT_W-1:0]  latency_i,
  input  wire logic signed [lbh_pkg::LBH_REQ_W-1:0]  req_count_i,
  input  wire logic signed [lbh_pkg::LBH_BYTE_W-1:0] req_bytes_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       kind_o,
  output logic                                       status_o,
  output logic             [lbh_pkg::LBH_ROW_W-1:0]  row_index_o,
  output logic             [lbh_pkg::LBH_COL_W-1:0]  col_index_o,
  output logic             [lbh_pkg::LBH_CNT_W-1:0]  cell_count_o,
  output logic             [lbh_pkg::LBH_TOT_W-1:0]  total_requests_o,
  output logic signed      [lbh_pkg::LBH_TOT_W-1:0]  total_bytes_o,
  output logic                                       last_o
);
  import lbh_pkg::*;

  localparam int DEPTH = LATENCY_BINS * BATCH_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(LATENCY_BINS);
  localparam int CW    = $clog2(BATCH_BINS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  lbh_state_e state_q, state_d;

  logic [LBH_THR_W-1:0] thr_q;

  logic [AW-1:0] bin_addr;
  logic          rej_in;

  logic          cmd_q, rej_q;
  logic [AW-1:0] addr_q;

  logic [AW-1:0] sw_q;
  logic [RW-1:0] sw_row_q;
  logic [CW-1:0] sw_col_q;
  logic          sw_adv;

  logic                 pend_v_q, pend_ld, pend_clr;
  logic [RW-1:0]        pend_row_q;
  logic [CW-1:0]        pend_col_q;
  logic [LBH_CNT_W-1:0] pend_cnt_q;

  logic [AW-1:0]        ram_addr;
  logic                 ram_re, ram_we;
  logic [LBH_CNT_W-1:0] ram_wdata, ram_rdata;

  lbh_tot_ctl_t                tot_ctl;
  logic        [LBH_TOT_W-1:0] tot_req;
  logic signed [LBH_TOT_W-1:0] tot_bytes;
  logic                        tot_hit;
  logic                        dump_go;

  logic                 slot_free, out_ld;
  logic                 out_valid_q;
  logic                 o_kind_d, o_stat_d, o_last_d;
  logic [RW-1:0]        o_row_d;
  logic [CW-1:0]        o_col_d;
  logic [LBH_CNT_W-1:0] o_cnt_d;
  logic                 o_tot_d;
  logic                 kind_q, stat_q, last_q;
  logic [RW-1:0]        row_q;
  logic [CW-1:0]        col_q;
  logic [LBH_CNT_W-1:0] cnt_q;
  logic [LBH_TOT_W-1:0] treq_q;
  logic signed [LBH_TOT_W-1:0] tbyt_q;

  lbh_bin_map #(
    .LATENCY_BINS (LATENCY_BINS),
    .BATCH_BINS   (BATCH_BINS),
    .RW           (RW),
    .CW           (CW),
    .AW           (AW)
  ) u_bin_map (
    .cmd_i       (cmd_i),
    .latency_i   (latency_i),
    .req_count_i (req_count_i),
    .addr_o      (bin_addr)
  );

  lbh_cell_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (LBH_CNT_W)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .re_i    (ram_re),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  lbh_totals u_totals (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (tot_ctl),
    .req_count_i   (req_count_i),
    .req_bytes_i   (req_bytes_i),
    .thr_i         (thr_q),
    .total_req_o   (tot_req),
    .total_bytes_o (tot_bytes),
    .hit_o         (tot_hit)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign rej_in      = (cmd_i == LBH_CMD_BATCH) &&
                       (req_count_i[LBH_REQ_W-1] || (req_count_i == '0));
  assign dump_go     = (cmd_q == LBH_CMD_BATCH) && !rej_q && tot_hit;

  always_comb begin
    state_d   = state_q;
    ram_addr  = addr_q;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = '0;
    tot_ctl   = '0;
    sw_adv    = 1'b0;
    pend_ld   = 1'b0;
    pend_clr  = 1'b0;
    out_ld    = 1'b0;
    o_kind_d  = LBH_KIND_STAT;
    o_stat_d  = LBH_STAT_OK;
    o_row_d   = '0;
    o_col_d   = '0;
    o_cnt_d   = '0;
    o_tot_d   = 1'b0;
    o_last_d  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ram_addr = sw_q;
        ram_we   = 1'b1;
        sw_adv   = 1'b1;
        if (sw_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ram_addr = bin_addr;
        if (in_valid_i) begin
          ram_re      = 1'b1;
          tot_ctl.add = (cmd_i == LBH_CMD_BATCH) && !rej_in;
          state_d     = S_WRITE;
        end
      end
      S_WRITE: begin
        if (slot_free) begin
          ram_we    = !rej_q;
          ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
          out_ld    = 1'b1;
          o_stat_d  = rej_q ? LBH_STAT_REJ : LBH_STAT_OK;
          o_last_d  = !dump_go;
          state_d   = dump_go ? S_DRD : S_IDLE;
        end
      end
      S_DRD: begin
        // read the cell and zero it in the same cycle
        ram_addr = sw_q;
        ram_re   = 1'b1;
        ram_we   = 1'b1;
        state_d  = S_DCHK;
      end
      S_DCHK: begin
        if (ram_rdata == '0 || !pend_v_q || slot_free) begin
          if (ram_rdata != '0) begin
            pend_ld = 1'b1;
            if (pend_v_q) begin
              out_ld   = 1'b1;
              o_kind_d = LBH_KIND_CELL;
              o_row_d  = pend_row_q;
              o_col_d  = pend_col_q;
              o_cnt_d  = pend_cnt_q;
              o_tot_d  = 1'b1;
            end
          end
          sw_adv  = 1'b1;
          state_d = (sw_q == LAST_ADDR) ? S_FLUSH : S_DRD;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_ld        = 1'b1;
          o_kind_d      = LBH_KIND_CELL;
          o_row_d       = pend_row_q;
          o_col_d       = pend_col_q;
          o_cnt_d       = pend_cnt_q;
          o_tot_d       = 1'b1;
          o_last_d      = 1'b1;
          pend_clr      = 1'b1;
          tot_ctl.clear = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      thr_q       <= LBH_THR_RESET;
      sw_q        <= '0;
      sw_row_q    <= '0;
      sw_col_q    <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= LBH_CMD_PLAIN;
      rej_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        thr_q <= cfg_data_i;
      end
      if (state_q == S_IDLE && in_valid_i) begin
        cmd_q <= cmd_i;
        rej_q <= rej_in;
      end
      // walk address, row and column together; wrap for the next sweep
      if (sw_adv) begin
        if (sw_q == LAST_ADDR) begin
          sw_q     <= '0;
          sw_row_q <= '0;
          sw_col_q <= '0;
        end else begin
          sw_q <= sw_q + 1'b1;
          if (sw_col_q == CW'(BATCH_BINS - 1)) begin
            sw_col_q <= '0;
            sw_row_q <= sw_row_q + 1'b1;
          end else begin
            sw_col_q <= sw_col_q + 1'b1;
          end
        end
      end
      if (pend_ld) begin
        pend_v_q <= 1'b1;
      end else if (pend_clr) begin
        pend_v_q <= 1'b0;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      addr_q <= bin_addr;
    end
    if (pend_ld) begin
      pend_row_q <= sw_row_q;
      pend_col_q <= sw_col_q;
      pend_cnt_q <= ram_rdata;
    end
    if (out_ld) begin
      kind_q <= o_kind_d;
      stat_q <= o_stat_d;
      row_q  <= o_row_d;
      col_q  <= o_col_d;
      cnt_q  <= o_cnt_d;
      treq_q <= o_tot_d ? tot_req : '0;
      tbyt_q <= o_tot_d ? tot_bytes : '0;
      last_q <= o_last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign status_o         = stat_q;
  assign row_index_o      = LBH_ROW_W'(row_q);
  assign col_index_o      = LBH_COL_W'(col_q);
  assign cell_count_o     = cnt_q;
  assign total_requests_o = treq_q;
  assign total_bytes_o    = tbyt_q;
  assign last_o           = last_q;

`ifndef SYNTHESIS
  a_flush_has_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |-> pend_v_q)
    else $error("flush without a pending cell");

  a_dump_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && slot_free && dump_go) |=> (state_q == S_DRD && sw_q == '0))
    else $error("dump did not start at the first cell");

  a_totals_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH && slot_free) |=> (tot_req == '0 && !pend_v_q))
    else $error("totals or pending cell not cleared after dump");

  a_cell_word_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ld && o_kind_d == LBH_KIND_CELL) |-> (o_cnt_d != '0))
    else $error("zero cell emitted in dump");
`endif

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for log2_latency_batch_histogram_unit: directed and random inserts,
// threshold dumps and large byte totals of both signs, checked against an in-bench tally.
// Depends on lbh_pkg and the block's RTL only.
module testbench;
  import lbh_pkg::*;

  localparam int ROWS = 8;
  localparam int COLS = 4;
  localparam int SETTLE = 2 * ROWS * COLS + 8;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int BYTE_RUN = 4;
  localparam logic [LBH_TOT_W-1:0] REQ_CEIL = '1;
  localparam longint BYTES_CEIL = 64'sd140737488355327;
  localparam longint BYTES_FLOOR = -64'sd140737488355328;

  typedef struct packed {
    logic                 kind;
    logic                 status;
    logic [LBH_ROW_W-1:0] row;
    logic [LBH_COL_W-1:0] col;
    logic [LBH_CNT_W-1:0] hits;
    logic [LBH_TOT_W-1:0] reqs;
    logic [LBH_TOT_W-1:0] byte_sum;
    logic                 last;
  } hist_word_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LBH_THR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic [LBH_LAT_W-1:0] latency = '0;
  logic signed [LBH_REQ_W-1:0] req_count = '0;
  logic signed [LBH_BYTE_W-1:0] req_bytes = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic kind;
  logic status;
  logic [LBH_ROW_W-1:0] row_index;
  logic [LBH_COL_W-1:0] col_index;
  logic [LBH_CNT_W-1:0] cell_count;
  logic [LBH_TOT_W-1:0] total_requests;
  logic signed [LBH_TOT_W-1:0] total_bytes;
  logic last;

  // in-bench copy of the histogram state
  logic [LBH_CNT_W-1:0] tally [ROWS][COLS];
  longint unsigned req_sum = 0;
  longint byte_sum = 0;
  logic [LBH_THR_W-1:0] dump_level = LBH_THR_RESET;
  hist_word_t words_due[$];

  int mismatches = 0;
  bit quiet = 1'b0;
  longint cycles = 0;

  log2_latency_batch_histogram_unit #(
    .LATENCY_BINS(ROWS),
    .BATCH_BINS  (COLS)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .latency_i       (latency),
    .req_count_i     (req_count),
    .req_bytes_i     (req_bytes),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .kind_o          (kind),
    .status_o        (status),
    .row_index_o     (row_index),
    .col_index_o     (col_index),
    .cell_count_o    (cell_count),
    .total_requests_o(total_requests),
    .total_bytes_o   (total_bytes),
    .last_o          (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(0, 3));
    return int'($urandom_range(8, 40));
  endfunction

  function automatic logic [LBH_LAT_W-1:0] rand_latency();
    logic [LBH_LAT_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) return '0;
    return v >> $urandom_range(0, 63);
  endfunction

  task automatic clear_tally();
    for (int r = 0; r < ROWS; r++)
      for (int k = 0; k < COLS; k++)
        tally[r][k] = '0;
    req_sum = 0;
    byte_sum = 0;
  endtask

  // Bin one accepted word and queue the status word plus any dumped cells.
  task automatic tally_insert(input logic c, input logic [LBH_LAT_W-1:0] lat,
                              input logic signed [LBH_REQ_W-1:0] cnt,
                              input logic signed [LBH_BYTE_W-1:0] nbytes);
    hist_word_t w;
    hist_word_t tail;
    int row;
    int col;
    row = 0;
    for (int b = 1; b < LBH_LAT_W; b++)
      if (lat[b]) row = b;
    if (row > ROWS - 1) row = ROWS - 1;
    w = '0;
    w.kind = LBH_KIND_STAT;
    w.status = LBH_STAT_OK;
    w.last = 1'b1;
    if (c == LBH_CMD_PLAIN) begin
      if (tally[row][0] != '1) tally[row][0] = tally[row][0] + 1'b1;
      words_due.push_back(w);
    end else if (cnt < 1) begin
      w.status = LBH_STAT_REJ;
      words_due.push_back(w);
    end else begin
      req_sum = req_sum + longint'(cnt);
      if (req_sum > REQ_CEIL) req_sum = REQ_CEIL;
      byte_sum = byte_sum + longint'(nbytes);
      if (byte_sum > BYTES_CEIL) byte_sum = BYTES_CEIL;
      if (byte_sum < BYTES_FLOOR) byte_sum = BYTES_FLOOR;
      col = (cnt > COLS - 1) ? COLS - 1 : int'(cnt);
      if (tally[row][col] != '1) tally[row][col] = tally[row][col] + 1'b1;
      if (req_sum >= dump_level) begin
        w.last = 1'b0;
        words_due.push_back(w);
        for (int r = 0; r < ROWS; r++) begin
          for (int k = 0; k < COLS; k++) begin
            if (tally[r][k] != '0) begin
              w = '0;
              w.kind = LBH_KIND_CELL;
              w.status = LBH_STAT_OK;
              w.row = LBH_ROW_W'(r);
              w.col = LBH_COL_W'(k);
              w.hits = tally[r][k];
              w.reqs = req_sum[LBH_TOT_W-1:0];
              w.byte_sum = byte_sum[LBH_TOT_W-1:0];
              words_due.push_back(w);
            end
          end
        end
        // flag the final cell of the dump
        tail = words_due.pop_back();
        tail.last = 1'b1;
        words_due.push_back(tail);
        clear_tally();
      end else begin
        words_due.push_back(w);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %h, got %h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_words
    hist_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (words_due.size() == 0) begin
        $error("unexpected result word: kind %b row %0d col %0d", kind, row_index, col_index);
        mismatches++;
      end else begin
        want = words_due.pop_front();
        check_field("kind", 64'(want.kind), 64'(kind));
        check_field("status", 64'(want.status), 64'(status));
        check_field("row_index", 64'(want.row), 64'(row_index));
        check_field("col_index", 64'(want.col), 64'(col_index));
        check_field("cell_count", 64'(want.hits), 64'(cell_count));
        check_field("total_requests", 64'(want.reqs), 64'(total_requests));
        check_field("total_bytes", 64'(want.byte_sum), 64'($unsigned(total_bytes)));
        check_field("last", 64'(want.last), 64'(last));
      end
    end
  end

  initial begin : stall_gen
    int run;
    run = 0;
    forever begin
      @(negedge clk);
      if (run > 0) begin
        run--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 2) == 0);
        run = gap_len();
      end
    end
  end

  // Entered and left at a falling edge; valid stays high into the next word.
  task automatic send_word(input logic c, input logic [LBH_LAT_W-1:0] lat,
                           input logic signed [LBH_REQ_W-1:0] cnt,
                           input logic signed [LBH_BYTE_W-1:0] nbytes);
    int gap;
    gap = quiet ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    latency <= lat;
    req_count <= cnt;
    req_bytes <= nbytes;
    do @(posedge clk); while (in_stall);
    tally_insert(c, lat, cnt, nbytes);
    @(negedge clk);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    // let a sweep that is still clearing the table finish
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [LBH_THR_W-1:0] level);
    drain_words();
    cfg_valid <= 1'b1;
    cfg_data <= level;
    do @(posedge clk); while (!cfg_ready);
    dump_level = level;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_item(input int max_batch);
    int pick;
    logic signed [LBH_REQ_W-1:0] cnt;
    pick = int'($urandom_range(0, 9));
    if (pick < 3) begin
      send_word(LBH_CMD_PLAIN, rand_latency(), LBH_REQ_W'($urandom), $urandom);
    end else if (pick == 3) begin
      cnt = LBH_REQ_W'($urandom_range(0, 32768));
      cnt = -cnt;
      send_word(LBH_CMD_BATCH, rand_latency(), cnt, $urandom);
    end else begin
      if ($urandom_range(0, 7) == 0) cnt = LBH_REQ_W'($urandom_range(1, 32767));
      else cnt = LBH_REQ_W'($urandom_range(1, max_batch));
      send_word(LBH_CMD_BATCH, rand_latency(), cnt, $urandom);
    end
  endtask

  task automatic test_plain_rows();
    send_word(LBH_CMD_PLAIN, 64'd0, 16'sd0, 32'sd0);
    send_word(LBH_CMD_PLAIN, 64'd1, 16'sd5, 32'sd1);
    send_word(LBH_CMD_PLAIN, 64'd2, 16'sd1, 32'sd0);
    send_word(LBH_CMD_PLAIN, 64'd3, 16'sh7FFF, 32'sh7FFF_FFFF);
    send_word(LBH_CMD_PLAIN, 64'd255, 16'sd2, 32'sd0);
    send_word(LBH_CMD_PLAIN, 64'd256, 16'sd3, 32'sd0);
    send_word(LBH_CMD_PLAIN, 64'h8000_0000_0000_0000, 16'sd0, 32'sd0);
    // totals stay put even with a hostile count and byte field
    send_word(LBH_CMD_PLAIN, '1, 16'sh8000, 32'sh8000_0000);
  endtask

  task automatic test_rejects();
    send_word(LBH_CMD_BATCH, 64'd40, 16'sd0, 32'sd100);
    send_word(LBH_CMD_BATCH, 64'd7, -16'sd1, 32'sh7FFF_FFFF);
    send_word(LBH_CMD_BATCH, '1, 16'sh8000, 32'sh8000_0000);
  endtask

  // Reset threshold of 1024: walk the columns, land exactly on it, then overshoot.
  task automatic test_default_dump();
    send_word(LBH_CMD_BATCH, 64'd4, 16'sd1, 32'sh7FFF_FFFF);
    send_word(LBH_CMD_BATCH, 64'd16, 16'sd2, 32'sh8000_0000);
    send_word(LBH_CMD_BATCH, 64'd0, 16'sd3, 32'sd1000);
    send_word(LBH_CMD_BATCH, 64'd100, 16'sd4, -32'sd77);
    send_word(LBH_CMD_BATCH, 64'hFFFF, 16'sd1000, 32'sd5);
    send_word(LBH_CMD_BATCH, 64'd1, 16'sd13, 32'sd0);
    send_word(LBH_CMD_BATCH, 64'd9, 16'sd1, 32'sd1);
    send_word(LBH_CMD_BATCH, '1, 16'sh7FFF, 32'sh7FFF_FFFF);
  endtask

  task automatic test_threshold_sweep();
    logic [LBH_THR_W-1:0] levels [8];
    int span [8];
    levels = '{32'd1, 32'd0, LBH_THR_W'($urandom_range(2, 16)), 32'd1024,
               LBH_THR_W'($urandom_range(20, 5000)), $urandom, '1, 32'd1};
    span = '{3, 3, 2, 8, 64, 1000, 8, 3};
    for (int p = 0; p < 8; p++) begin
      write_threshold(levels[p]);
      quiet = (p == 3);
      for (int i = 0; i < 24; i++) begin
        // hold the sender once until every word has come back
        if (p == 4 && i == 13) drain_words();
        send_random_item(span[p]);
      end
    end
    quiet = 1'b0;
  endtask

  // Pile up large byte sums of each sign; an all-ones threshold holds off a dump.
  task automatic test_byte_totals();
    quiet = 1'b1;
    write_threshold('1);
    repeat (BYTE_RUN) send_word(LBH_CMD_BATCH, rand_latency(), 16'sd1, 32'sh7FFF_FFFF);
    send_word(LBH_CMD_BATCH, rand_latency(), 16'sd1, 32'sh8000_0000);
    send_word(LBH_CMD_BATCH, rand_latency(), 16'sd1, 32'sh7FFF_FFFF);
    write_threshold(32'd1);
    send_word(LBH_CMD_BATCH, rand_latency(), 16'sd1, 32'sd0);
    write_threshold('1);
    repeat (BYTE_RUN) send_word(LBH_CMD_BATCH, rand_latency(), 16'sd1, 32'sh8000_0000);
    send_word(LBH_CMD_BATCH, rand_latency(), 16'sd2, 32'sh7FFF_FFFF);
    send_word(LBH_CMD_BATCH, rand_latency(), 16'sd1, 32'sh8000_0000);
    write_threshold(32'd1);
    send_word(LBH_CMD_BATCH, rand_latency(), 16'sd1, 32'sd0);
    quiet = 1'b0;
  endtask

  initial begin
    clear_tally();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_plain_rows();
    test_rejects();
    test_default_dump();
    test_threshold_sweep();
    test_byte_totals();
    drain_words();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
design/lbh_pkg.sv
design/lbh_cell_ram.sv
design/lbh_bin_map.sv
design/lbh_totals.sv
design/log2_latency_batch_histogram_unit.sv
test/testbench.sv
